>>> rtl/core/oipp_pkg.sv
// Shared constants, types and tables of the onset interval period and phase estimator.
`default_nettype none

package oipp_pkg;

  // Q8.16 seconds
  localparam int unsigned TIME_W  = 24;
  localparam int unsigned TOL_W   = 16;
  localparam int unsigned SUM_W   = 32;
  localparam int unsigned PHASE_W = 17;
  localparam int unsigned COUNT_W = 9;
  localparam int unsigned CFG_W   = 24;
  localparam int unsigned CFG_IDX_W = 1;

  localparam int unsigned WINDOW_LENGTH_DEF = 64;
  localparam int unsigned MAX_DIVISOR_DEF   = 5;

  localparam logic [TIME_W-1:0] MINIMUM_CAP_RST     = 24'd6553600;
  localparam logic [TOL_W-1:0]  MATCH_TOLERANCE_RST = 16'd6554;

  // floor(v / x) == (v * ceil(2^27 / x)) >> 27 for every 24-bit v and x up to 8
  localparam int unsigned RECIP_W     = 28;
  localparam int unsigned RECIP_SHIFT = 27;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_MINIMUM_CAP = 1'b0,
    REG_MATCH_TOL   = 1'b1
  } cfg_reg_e;

  function automatic logic [RECIP_W-1:0] recip_of(input logic [3:0] x);
    logic [RECIP_W-1:0] r;
    case (x)
      4'd1:    r = 28'd134217728;
      4'd2:    r = 28'd67108864;
      4'd3:    r = 28'd44739243;
      4'd4:    r = 28'd33554432;
      4'd5:    r = 28'd26843546;
      4'd6:    r = 28'd22369622;
      4'd7:    r = 28'd19173962;
      4'd8:    r = 28'd16777216;
      default: r = 28'd134217728;
    endcase
    return r;
  endfunction

endpackage

`default_nettype wire

>>> rtl/core/onset_interval_period_phase.sv
// Onset interval period and phase estimator: window store, match pipeline and shared divider.
`default_nettype none

// Intervals of a window are written one per cycle while in_stall_o is low into a 24-bit wide
// synchronous memory of WINDOW_LENGTH entries; an item that does not close the window is taken
// without a stall. The item marked last starts the estimate: the memory is read back once per
// (interval, divisor) pair for every stored interval after the first, one pair per cycle
// through a three-stage match pipeline, followed by pipeline drain, setup and result
// hand-off. A one-bit-per-cycle restoring divider then runs up to three times: 33 steps for
// the period, 26 for the elapsed-time remainder and 41 for the phase fraction, each followed
// by a step that takes its result. While the estimate runs, in_stall_o is high; the result
// waits in an output register, and the next window can be filled while it is not yet taken.
module onset_interval_period_phase #(
  parameter int unsigned WINDOW_LENGTH = oipp_pkg::WINDOW_LENGTH_DEF,
  parameter int unsigned MAX_DIVISOR   = oipp_pkg::MAX_DIVISOR_DEF
) (
  input  wire                                clk_i,
  input  wire                                rst_ni,
  // configuration
  input  wire                                cfg_we_i,
  input  wire [oipp_pkg::CFG_IDX_W-1:0]      cfg_index_i,
  input  wire [oipp_pkg::CFG_W-1:0]          cfg_data_i,
  // request in
  input  wire                                in_valid_i,
  output logic                               in_stall_o,
  input  wire [oipp_pkg::TIME_W-1:0]         interval_i,
  input  wire [oipp_pkg::TIME_W-1:0]         elapsed_since_onset_i,
  input  wire                                last_i,
  // result out
  output logic                               out_valid_o,
  input  wire                                out_stall_i,
  output logic [oipp_pkg::TIME_W-1:0]        period_o,
  output logic [oipp_pkg::PHASE_W-1:0]       phase_turns_o,
  output logic [oipp_pkg::COUNT_W-1:0]       match_count_o,
  output logic                               estimate_valid_o
);

  localparam int unsigned TIME_W    = oipp_pkg::TIME_W;
  localparam int unsigned TOL_W     = oipp_pkg::TOL_W;
  localparam int unsigned SUM_W     = oipp_pkg::SUM_W;
  localparam int unsigned PHASE_W   = oipp_pkg::PHASE_W;
  localparam int unsigned COUNT_W   = oipp_pkg::COUNT_W;
  localparam int unsigned IDX_W     = $clog2(WINDOW_LENGTH);
  localparam int unsigned POS_W     = $clog2(WINDOW_LENGTH + 1);
  localparam int unsigned XW        = $clog2(MAX_DIVISOR + 1);
  localparam int unsigned XS_W      = TIME_W + XW;
  localparam int unsigned CMP_W     = XS_W + TOL_W;
  localparam int unsigned CNT_W     = $clog2((WINDOW_LENGTH - 1) * MAX_DIVISOR + 1);
  localparam int unsigned CNTX_W    = (CNT_W > COUNT_W) ? CNT_W : COUNT_W;
  localparam int unsigned PROD_W    = TIME_W + oipp_pkg::RECIP_W;
  localparam int unsigned DVD_W     = TIME_W + TOL_W + 1;
  localparam int unsigned PER_STEPS = SUM_W + 1;
  localparam int unsigned MOD_STEPS = TIME_W + 2;
  localparam int unsigned DCNT_W    = $clog2(DVD_W + 1);

  localparam logic [TIME_W-1:0]  TIME_MAX  = {TIME_W{1'b1}};
  localparam logic [SUM_W-1:0]   SUM_MAX   = {SUM_W{1'b1}};
  localparam logic [COUNT_W-1:0] COUNT_MAX = {COUNT_W{1'b1}};
  localparam logic [XW-1:0]      X_FIRST   = XW'(1);
  localparam logic [XW-1:0]      X_LAST    = XW'(MAX_DIVISOR);
  localparam logic [PHASE_W-1:0] PHASE_MAX = PHASE_W'(1 << TOL_W);

  typedef enum logic [3:0] {
    S_IDLE,
    S_EVAL,
    S_DRAIN0,
    S_DRAIN1,
    S_SETUP,
    S_PER,
    S_MOD,
    S_PHASE,
    S_DONE
  } state_e;

  state_e state_q;

  // configuration
  logic [TIME_W-1:0] cap_q;
  logic [TOL_W-1:0]  tol_q;

  // window state
  logic [TIME_W-1:0] mem [WINDOW_LENGTH];
  logic [TIME_W-1:0] mem_rdata_q;
  logic [POS_W-1:0]  pos_q;
  logic [TIME_W-1:0] smallest_q;
  logic [TIME_W-1:0] elapsed_q;
  logic [SUM_W-1:0]  sum_q;
  logic [CNT_W-1:0]  cnt_q;

  // pair sequencer
  logic [IDX_W-1:0]  idx_q;
  logic [XW-1:0]     x_q;

  // match pipeline
  logic              s0_vld_q;
  logic [XW-1:0]     s0_x_q;
  logic [XS_W-1:0]   s0_xs_q;
  logic              s1_vld_q;
  logic [XS_W-1:0]   s1_diff_q;
  logic [CMP_W-1:0]  s1_rhs_q;
  logic [TIME_W-1:0] s1_quo_q;

  // divider
  logic [TIME_W-1:0] dvs_q;
  logic [TIME_W-1:0] rem_q;
  logic [DVD_W-1:0]  quo_q;
  logic [DCNT_W-1:0] div_cnt_q;

  // results
  logic [TIME_W-1:0]  per_q;
  logic [PHASE_W-1:0] phase_q;
  logic               out_valid_q;
  logic [TIME_W-1:0]  out_period_q;
  logic [PHASE_W-1:0] out_phase_q;
  logic [COUNT_W-1:0] out_count_q;
  logic               out_est_q;

  logic              in_fire;
  logic [POS_W-1:0]  pos_d;
  logic              pair_last;
  logic [XS_W-1:0]   v_ext;
  logic [XS_W-1:0]   diff_d;
  logic [CMP_W-1:0]  rhs_d;
  logic [PROD_W-1:0] quo_prod;
  logic              match;
  logic [SUM_W:0]    sum_add;
  logic [TIME_W:0]   div_shift;
  logic              div_ge;
  logic [TIME_W-1:0] div_rem_d;
  logic [DVD_W-1:0]  div_quo_d;
  logic [TIME_W-1:0] per_d;
  logic [TIME_W-1:0] mod_r;
  logic [PER_STEPS-1:0] per_dvd;
  logic [DVD_W-1:0]  ph_dvd;
  logic [CNTX_W-1:0] cnt_x;

  assign in_stall_o = (state_q != S_IDLE);
  assign in_fire    = in_valid_i && !in_stall_o;
  assign pos_d      = (pos_q < POS_W'(WINDOW_LENGTH)) ? pos_q + POS_W'(1) : pos_q;
  assign pair_last  = (x_q == X_LAST) && (POS_W'(idx_q) == pos_q - POS_W'(1));

  // stage 1: distance to x * smallest, tolerance bound and floor(v / x)
  assign v_ext    = XS_W'(mem_rdata_q);
  assign diff_d   = (v_ext > s0_xs_q) ? v_ext - s0_xs_q : s0_xs_q - v_ext;
  assign rhs_d    = CMP_W'(tol_q) * CMP_W'(s0_xs_q);
  assign quo_prod = PROD_W'(mem_rdata_q) * PROD_W'(oipp_pkg::recip_of(4'(s0_x_q)));

  // stage 2: |v - x*s| * 2^16 < tol * x*s
  assign match   = {s1_diff_q, {TOL_W{1'b0}}} < s1_rhs_q;
  assign sum_add = {1'b0, sum_q} + (SUM_W + 1)'(s1_quo_q);

  // restoring divider, one quotient bit a cycle
  assign div_shift = {rem_q, quo_q[DVD_W-1]};
  assign div_ge    = div_shift >= {1'b0, dvs_q};
  assign div_rem_d = div_ge ? TIME_W'(div_shift - {1'b0, dvs_q}) : div_shift[TIME_W-1:0];
  assign div_quo_d = {quo_q[DVD_W-2:0], div_ge};

  assign per_d   = (|quo_q[DVD_W-1:TIME_W]) ? TIME_MAX : quo_q[TIME_W-1:0];
  assign mod_r   = (rem_q == '0) ? per_q : rem_q;
  assign per_dvd = {1'b0, sum_q} + PER_STEPS'(cnt_q >> 1);
  assign ph_dvd  = DVD_W'({mod_r, {TOL_W{1'b0}}}) + DVD_W'(per_q >> 1);
  assign cnt_x   = CNTX_W'(cnt_q);

  // window memory and match pipeline payload
  always_ff @(posedge clk_i) begin
    if (in_fire && pos_q < POS_W'(WINDOW_LENGTH)) begin
      mem[pos_q[IDX_W-1:0]] <= interval_i;
    end
    mem_rdata_q <= mem[idx_q];
    s0_x_q      <= x_q;
    s0_xs_q     <= XS_W'(x_q) * XS_W'(smallest_q);
    s1_diff_q   <= diff_d;
    s1_rhs_q    <= rhs_d;
    s1_quo_q    <= quo_prod[oipp_pkg::RECIP_SHIFT +: TIME_W];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_IDLE;
      cap_q        <= oipp_pkg::MINIMUM_CAP_RST;
      tol_q        <= oipp_pkg::MATCH_TOLERANCE_RST;
      pos_q        <= '0;
      smallest_q   <= oipp_pkg::MINIMUM_CAP_RST;
      elapsed_q    <= '0;
      sum_q        <= '0;
      cnt_q        <= '0;
      idx_q        <= '0;
      x_q          <= X_FIRST;
      s0_vld_q     <= 1'b0;
      s1_vld_q     <= 1'b0;
      dvs_q        <= '0;
      rem_q        <= '0;
      quo_q        <= '0;
      div_cnt_q    <= '0;
      per_q        <= '0;
      phase_q      <= '0;
      out_valid_q  <= 1'b0;
      out_period_q <= '0;
      out_phase_q  <= '0;
      out_count_q  <= '0;
      out_est_q    <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_index_i)
          oipp_pkg::REG_MINIMUM_CAP: cap_q <= cfg_data_i[TIME_W-1:0];
          oipp_pkg::REG_MATCH_TOL:   tol_q <= cfg_data_i[TOL_W-1:0];
          default: ;
        endcase
      end

      // S_DONE reloads the output register itself
      if (out_valid_q && !out_stall_i && state_q != S_DONE) begin
        out_valid_q <= 1'b0;
      end

      s0_vld_q <= (state_q == S_EVAL);
      s1_vld_q <= s0_vld_q;
      if (s1_vld_q && match) begin
        sum_q <= sum_add[SUM_W] ? SUM_MAX : sum_add[SUM_W-1:0];
        cnt_q <= cnt_q + CNT_W'(1);
      end

      if (div_cnt_q != '0) begin
        rem_q     <= div_rem_d;
        quo_q     <= div_quo_d;
        div_cnt_q <= div_cnt_q - DCNT_W'(1);
      end

      case (state_q)
        S_IDLE: begin
          if (in_fire) begin
            if (pos_q == '0) begin
              smallest_q <= cap_q;
            end else if (pos_q < POS_W'(WINDOW_LENGTH) && interval_i < smallest_q) begin
              smallest_q <= interval_i;
            end
            pos_q <= pos_d;
            if (last_i) begin
              elapsed_q <= elapsed_since_onset_i;
              idx_q     <= IDX_W'(1);
              x_q       <= X_FIRST;
              state_q   <= (pos_d > POS_W'(1)) ? S_EVAL : S_SETUP;
            end
          end
        end
        S_EVAL: begin
          if (x_q == X_LAST) begin
            x_q   <= X_FIRST;
            idx_q <= idx_q + IDX_W'(1);
          end else begin
            x_q <= x_q + XW'(1);
          end
          if (pair_last) begin
            state_q <= S_DRAIN0;
          end
        end
        S_DRAIN0: state_q <= S_DRAIN1;
        S_DRAIN1: state_q <= S_SETUP;
        S_SETUP: begin
          if (cnt_q == '0) begin
            per_q   <= '0;
            phase_q <= '0;
            state_q <= S_DONE;
          end else begin
            // rounded average: (sum + count/2) / count
            dvs_q     <= TIME_W'(cnt_q);
            rem_q     <= '0;
            quo_q     <= DVD_W'(per_dvd) << (DVD_W - PER_STEPS);
            div_cnt_q <= DCNT_W'(PER_STEPS);
            state_q   <= S_PER;
          end
        end
        S_PER: begin
          if (div_cnt_q == '0) begin
            per_q <= per_d;
            if (per_d == '0 || elapsed_q == '0) begin
              phase_q <= '0;
              state_q <= S_DONE;
            end else begin
              // remainder: (4 * elapsed) mod period
              dvs_q     <= per_d;
              rem_q     <= '0;
              quo_q     <= DVD_W'({elapsed_q, 2'b00}) << (DVD_W - MOD_STEPS);
              div_cnt_q <= DCNT_W'(MOD_STEPS);
              state_q   <= S_MOD;
            end
          end
        end
        S_MOD: begin
          if (div_cnt_q == '0) begin
            // exact multiple counts as a full turn
            rem_q     <= '0;
            quo_q     <= ph_dvd;
            div_cnt_q <= DCNT_W'(DVD_W);
            state_q   <= S_PHASE;
          end
        end
        S_PHASE: begin
          if (div_cnt_q == '0) begin
            phase_q <= quo_q[PHASE_W-1:0];
            state_q <= S_DONE;
          end
        end
        S_DONE: begin
          if (!out_valid_q || !out_stall_i) begin
            out_valid_q  <= 1'b1;
            out_period_q <= per_q;
            out_phase_q  <= phase_q;
            out_count_q  <= (cnt_x > CNTX_W'(COUNT_MAX)) ? COUNT_MAX : cnt_x[COUNT_W-1:0];
            out_est_q    <= (cnt_q != '0);
            pos_q        <= '0;
            smallest_q   <= cap_q;
            sum_q        <= '0;
            cnt_q        <= '0;
            state_q      <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  assign out_valid_o      = out_valid_q;
  assign period_o         = out_period_q;
  assign phase_turns_o    = out_phase_q;
  assign match_count_o    = out_count_q;
  assign estimate_valid_o = out_est_q;

  // the match pipeline is empty before the period division starts
  a_pipe_drained: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_SETUP) |-> (!s0_vld_q && !s1_vld_q))
    else $error("match pipeline busy at division setup");

  // a valid estimate goes with a nonzero count and back
  a_est_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (estimate_valid_o == (match_count_o != '0)))
    else $error("estimate_valid disagrees with match_count");

  // no matches gives an all-zero result
  a_no_match_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !estimate_valid_o) |-> (period_o == '0 && phase_turns_o == '0))
    else $error("nonzero period or phase without matches");

  // phase never exceeds one full turn
  a_phase_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (phase_turns_o <= PHASE_MAX))
    else $error("phase beyond one turn");

  // the divider only runs in its own states
  a_div_states: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (div_cnt_q != '0) |-> (state_q == S_PER || state_q == S_MOD || state_q == S_PHASE))
    else $error("divider stepping outside a division state");

endmodule

`default_nettype wire
